### sv/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants of the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

   localparam int MaxEvents = 4;
   localparam int QueueDepth = 4;
   localparam int QueueAddrW = $clog2(QueueDepth);
   localparam int CsrAddrW = 5;

   typedef enum logic [2:0] {
      EV_PRESS = 3'd0,
      EV_RELEASE = 3'd1,
      EV_CLICK = 3'd2,
      EV_DOUBLE = 3'd3,
      EV_LONG = 3'd4,
      EV_REPEAT = 3'd5
   } event_kind_type;

   typedef enum logic [2:0] {
      REG_DEBOUNCE_TIME = 3'd0,
      REG_LONG_PRESS_TIME = 3'd1,
      REG_DOUBLE_CLICK_TIME = 3'd2,
      REG_REPEAT_PERIOD = 3'd3,
      REG_PIN_INVERT = 3'd4,
      REG_LONG_PRESS_ENABLE = 3'd5,
      REG_DOUBLE_CLICK_ENABLE = 3'd6,
      REG_REPEAT_ENABLE = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [15:0] debounce_time;
      logic [15:0] long_press_time;
      logic [15:0] double_click_time;
      logic [15:0] repeat_period;
      logic        pin_invert;
      logic        long_press_enable;
      logic        double_click_enable;
      logic        repeat_enable;
   } cfg_type;

   // events of one tick, in emission order
   typedef struct packed {
      event_kind_type [MaxEvents-1:0] kinds;
      logic [1:0]                     last_idx;
      logic [31:0]                    time_stamp;
   } bundle_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

### sv/bgd_csr.sv
// ----------------------------------------------------------------------------
// bgd_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module bgd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bgd_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output bgd_pkg::cfg_type              cfg
);
   import bgd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx = reg_index_type'(csr_paddr[4:2]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_DEBOUNCE_TIME: cfg_in.debounce_time = csr_pwdata[15:0];
            REG_LONG_PRESS_TIME: cfg_in.long_press_time = csr_pwdata[15:0];
            REG_DOUBLE_CLICK_TIME: cfg_in.double_click_time = csr_pwdata[15:0];
            REG_REPEAT_PERIOD: cfg_in.repeat_period = csr_pwdata[15:0];
            REG_PIN_INVERT: cfg_in.pin_invert = csr_pwdata[0];
            REG_LONG_PRESS_ENABLE: cfg_in.long_press_enable = csr_pwdata[0];
            REG_DOUBLE_CLICK_ENABLE: cfg_in.double_click_enable = csr_pwdata[0];
            REG_REPEAT_ENABLE: cfg_in.repeat_enable = csr_pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_DEBOUNCE_TIME: csr_prdata = {16'd0, cfg_ff.debounce_time};
         REG_LONG_PRESS_TIME: csr_prdata = {16'd0, cfg_ff.long_press_time};
         REG_DOUBLE_CLICK_TIME: csr_prdata = {16'd0, cfg_ff.double_click_time};
         REG_REPEAT_PERIOD: csr_prdata = {16'd0, cfg_ff.repeat_period};
         REG_PIN_INVERT: csr_prdata = {31'd0, cfg_ff.pin_invert};
         REG_LONG_PRESS_ENABLE: csr_prdata = {31'd0, cfg_ff.long_press_enable};
         REG_DOUBLE_CLICK_ENABLE: csr_prdata = {31'd0, cfg_ff.double_click_enable};
         REG_REPEAT_ENABLE: csr_prdata = {31'd0, cfg_ff.repeat_enable};
         default: csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time <= 16'd20;
         cfg_ff.long_press_time <= 16'd1000;
         cfg_ff.double_click_time <= 16'd300;
         cfg_ff.repeat_period <= 16'd100;
         cfg_ff.pin_invert <= 1'b1;
         cfg_ff.long_press_enable <= 1'b1;
         cfg_ff.double_click_enable <= 1'b0;
         cfg_ff.repeat_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/bgd_front.sv
// ----------------------------------------------------------------------------
// bgd_front
// Tick engine: debounce, gesture timers and the event list of each tick.
// ----------------------------------------------------------------------------
module bgd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  bgd_pkg::cfg_type     cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_pin_level,
   input  logic                 queue_full,
   output logic                 push,
   output bgd_pkg::bundle_type  push_data
);
   import bgd_pkg::*;

   function automatic logic [15:0] bump(input logic [15:0] c);
      bump = (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   logic [31:0] tick_ff, tick_in;
   logic        prev_ff, prev_in;
   logic [15:0] dbc_ff, dbc_in;
   logic        db_armed_ff, db_armed_in;
   logic        stable_ff, stable_in;
   logic [31:0] press_ff, press_in;
   logic        await_ff, await_in;
   logic [15:0] dcc_ff, dcc_in;
   logic [15:0] lpc_ff, lpc_in;
   logic        lp_armed_ff, lp_armed_in;
   logic [15:0] rpc_ff, rpc_in;
   logic        rp_armed_ff, rp_armed_in;

   logic                           accept;
   logic                           level;
   logic [15:0]                    dc_bump, lp_bump, rp_bump, db_bump;
   logic [31:0]                    held;
   logic [2:0]                     n;
   event_kind_type [MaxEvents-1:0] kinds;

   assign req_stall = queue_full;
   assign accept = req_valid & ~queue_full;
   assign level = req_pin_level ^ cfg.pin_invert;
   assign dc_bump = bump(dcc_ff);
   assign lp_bump = bump(lpc_ff);
   assign rp_bump = bump(rpc_ff);
   assign db_bump = bump(dbc_ff);
   assign held = tick_ff - press_ff;

   always_comb begin
      tick_in = tick_ff + 32'd1;
      prev_in = prev_ff;
      dbc_in = dbc_ff;
      db_armed_in = db_armed_ff;
      stable_in = stable_ff;
      press_in = press_ff;
      await_in = await_ff;
      dcc_in = dcc_ff;
      lpc_in = lpc_ff;
      lp_armed_in = lp_armed_ff;
      rpc_in = rpc_ff;
      rp_armed_in = rp_armed_ff;
      n = 3'd0;
      kinds = '{default: EV_PRESS};

      // double click timeout
      if (await_ff) begin
         if (dc_bump >= cfg.double_click_time) begin
            await_in = 1'b0;
            dcc_in = 16'd0;
            kinds[n[1:0]] = EV_CLICK;
            n = n + 3'd1;
         end else begin
            dcc_in = dc_bump;
         end
      end

      // long press expiry
      if (lp_armed_ff) begin
         if (lp_bump >= cfg.long_press_time) begin
            lp_armed_in = 1'b0;
            lpc_in = 16'd0;
            kinds[n[1:0]] = EV_LONG;
            n = n + 3'd1;
            if (cfg.repeat_enable) begin
               rp_armed_in = 1'b1;
               rpc_in = 16'd0;
            end
         end else begin
            lpc_in = lp_bump;
         end
      end

      // auto repeat
      if (rp_armed_ff) begin
         if (rp_bump >= cfg.repeat_period) begin
            rpc_in = 16'd0;
            kinds[n[1:0]] = EV_REPEAT;
            n = n + 3'd1;
         end else begin
            rpc_in = rp_bump;
         end
      end

      // debounce
      if (level != prev_ff) begin
         prev_in = level;
         dbc_in = 16'd0;
         db_armed_in = 1'b1;
      end else if (db_armed_ff) begin
         if (db_bump >= cfg.debounce_time) begin
            db_armed_in = 1'b0;
            dbc_in = 16'd0;
            if (level != stable_ff) begin
               stable_in = level;
               if (level) begin
                  press_in = tick_ff;
                  if (cfg.long_press_enable) begin
                     lp_armed_in = 1'b1;
                     lpc_in = 16'd0;
                  end
                  kinds[n[1:0]] = EV_PRESS;
                  n = n + 3'd1;
               end else begin
                  lp_armed_in = 1'b0;
                  lpc_in = 16'd0;
                  rp_armed_in = 1'b0;
                  rpc_in = 16'd0;
                  if (held < {16'd0, cfg.long_press_time}) begin
                     if (cfg.double_click_enable) begin
                        if (await_in) begin
                           await_in = 1'b0;
                           dcc_in = 16'd0;
                           kinds[n[1:0]] = EV_DOUBLE;
                           n = n + 3'd1;
                        end else begin
                           await_in = 1'b1;
                           dcc_in = 16'd0;
                        end
                     end else begin
                        kinds[n[1:0]] = EV_CLICK;
                        n = n + 3'd1;
                     end
                  end
                  kinds[n[1:0]] = EV_RELEASE;
                  n = n + 3'd1;
               end
            end
         end else begin
            dbc_in = db_bump;
         end
      end
   end

   assign push = accept & (n != 3'd0);
   assign push_data.kinds = kinds;
   assign push_data.last_idx = n[1:0] - 2'd1;
   assign push_data.time_stamp = tick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= 32'd0;
         prev_ff <= 1'b0;
         dbc_ff <= 16'd0;
         db_armed_ff <= 1'b0;
         stable_ff <= 1'b0;
         press_ff <= 32'd0;
         await_ff <= 1'b0;
         dcc_ff <= 16'd0;
         lpc_ff <= 16'd0;
         lp_armed_ff <= 1'b0;
         rpc_ff <= 16'd0;
         rp_armed_ff <= 1'b0;
      end else if (accept) begin
         tick_ff <= tick_in;
         prev_ff <= prev_in;
         dbc_ff <= dbc_in;
         db_armed_ff <= db_armed_in;
         stable_ff <= stable_in;
         press_ff <= press_in;
         await_ff <= await_in;
         dcc_ff <= dcc_in;
         lpc_ff <= lpc_in;
         lp_armed_ff <= lp_armed_in;
         rpc_ff <= rpc_in;
         rp_armed_ff <= rp_armed_in;
      end
   end

endmodule

### sv/bgd_queue.sv
// ----------------------------------------------------------------------------
// bgd_queue
// Short queue of per-tick event bundles between the front and back parts.
// ----------------------------------------------------------------------------
module bgd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bgd_pkg::bundle_type       push_data,
   input  logic                      pop,
   output bgd_pkg::bundle_type       head,
   output bgd_pkg::queue_status_type status
);
   import bgd_pkg::*;

   bundle_type               mem [QueueDepth];
   logic [QueueAddrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QueueAddrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QueueAddrW:0]      count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full = (count_ff == (QueueAddrW+1)'(QueueDepth));
   assign do_push = push & ~status.full;
   assign do_pop = pop & ~status.empty;
   assign head = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (QueueAddrW+1)'(do_push) - (QueueAddrW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### sv/bgd_back.sv
// ----------------------------------------------------------------------------
// bgd_back
// Takes bundles apart into single events and drives the result register.
// ----------------------------------------------------------------------------
module bgd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  bgd_pkg::bundle_type       head,
   input  bgd_pkg::queue_status_type status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_event_kind,
   output logic [31:0]               rsp_time_stamp,
   output logic                      rsp_last_of_tick
);
   import bgd_pkg::*;

   logic [1:0]     sub_ff, sub_in;
   logic           valid_ff, valid_in;
   event_kind_type kind_ff, kind_in;
   logic [31:0]    stamp_ff, stamp_in;
   logic           last_ff, last_in;
   logic           load;
   logic           is_last;

   assign load = ~valid_ff | ~rsp_stall;
   assign is_last = (sub_ff == head.last_idx);
   assign pop = load & ~status.empty & is_last;

   always_comb begin
      sub_in = sub_ff;
      valid_in = valid_ff;
      kind_in = kind_ff;
      stamp_in = stamp_ff;
      last_in = last_ff;
      if (load) begin
         valid_in = ~status.empty;
         if (~status.empty) begin
            kind_in = head.kinds[sub_ff];
            stamp_in = head.time_stamp;
            last_in = is_last;
            sub_in = is_last ? 2'd0 : sub_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         valid_ff <= valid_in;
      end
      kind_ff <= kind_in;
      stamp_ff <= stamp_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_time_stamp = stamp_ff;
   assign rsp_last_of_tick = last_ff;

endmodule

### sv/button_gesture_detector_top.sv
// ----------------------------------------------------------------------------
// button_gesture_detector_top
// One button: debounce, press, release, click, double click, long press, repeat.
//
// Each req beat is one millisecond tick with the raw pin level. Each rsp beat
// is one event with its kind, the tick count it belongs to, and a flag on the
// last event of that tick; a tick gives zero to four events.
// The front engine takes one tick per cycle while the queue is not full and
// pushes the tick's events as a bundle into a four-deep queue; the back part
// sends them one per cycle. The first event of a tick passes through the
// queue and then the output register before it is valid on rsp.
// Throughput: one tick per cycle while the output keeps up; the rsp side
// moves one event per cycle while rsp_stall is low, so a tick's events go
// out one beat each. req_stall is high only while the queue is full.
// rsp_stall holds the output register; the queue fills and then stalls req.
// Reset restores the register defaults, clears all timers and tick count.
// Registers sit at byte addresses 4*i on the csr port.
// ----------------------------------------------------------------------------
module button_gesture_detector_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_pin_level,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_event_kind,
   output logic [31:0]                  rsp_time_stamp,
   output logic                         rsp_last_of_tick,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [bgd_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import bgd_pkg::*;

   cfg_type          cfg;
   logic             push;
   bundle_type       push_data;
   logic             pop;
   bundle_type       head;
   queue_status_type status;

   bgd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bgd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pin_level (req_pin_level),
      .queue_full    (status.full),
      .push          (push),
      .push_data     (push_data)
   );

   bgd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (status)
   );

   bgd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .status           (status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_time_stamp   (rsp_time_stamp),
      .rsp_last_of_tick (rsp_last_of_tick)
   );

endmodule

### tb/sv/button_gesture_detector_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector_top_tb
// Self-checking bench for the button gesture detector.
//
// Millisecond ticks go in on req. A local model of the debounce and gesture
// timers predicts the events of every accepted tick, and every rsp beat is
// compared with the oldest predicted event. A short table of ticks comes
// first; a few rows of it carry their expected events typed in. After that,
// random press and release runs with noise are sent under changing register
// settings. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module button_gesture_detector_top_tb;
   import bgd_pkg::*;

   localparam int NumDirected = 26;

   typedef struct packed {
      event_kind_type kind;
      logic [31:0]    stamp;
      logic           last;
   } gesture_beat_type;

   typedef struct packed {
      int             cfg_sel;
      logic           pin;
      logic           typed;
      int             ev_count;
      event_kind_type ev_kind;
   } tick_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_pin_level = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [2:0]          rsp_event_kind;
   logic [31:0]         rsp_time_stamp;
   logic                rsp_last_of_tick;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   // local copy of the detector state and its registers
   cfg_type       cfg = '{16'd20, 16'd1000, 16'd300, 16'd100, 1'b1, 1'b1, 1'b0, 1'b0};
   logic [31:0]   tick_cnt = '0;
   logic [31:0]   press_tick = '0;
   logic          last_sample = 1'b0;
   logic          stable_pressed = 1'b0;
   logic          deb_armed = 1'b0;
   logic          dc_waiting = 1'b0;
   logic          lp_armed = 1'b0;
   logic          rep_armed = 1'b0;
   logic [15:0]   deb_cnt = '0;
   logic [15:0]   dc_cnt = '0;
   logic [15:0]   lp_cnt = '0;
   logic [15:0]   rep_cnt = '0;

   gesture_beat_type tick_events[$];
   gesture_beat_type events_due[$];

   logic          steady_flow = 1'b0;
   int            failures = 0;
   int            beats_checked = 0;
   int            predicted_beats = 0;
   int            ticks_sent = 0;
   int            settings_count = 0;

   cfg_type directed_cfgs[3] = '{
      '{16'd1, 16'd3, 16'd2, 16'd1, 1'b0, 1'b1, 1'b0, 1'b1},
      '{16'd0, 16'd4, 16'd0, 16'd2, 1'b1, 1'b0, 1'b1, 1'b0},
      '{16'd0, 16'd4, 16'd5, 16'd2, 1'b1, 1'b1, 1'b1, 1'b1}
   };

   tick_row_type directed_rows[NumDirected] = '{
      '{-1, 1'b1, 1'b1, 0, EV_PRESS},
      '{-1, 1'b0, 1'b1, 0, EV_PRESS},
      '{ 0, 1'b1, 1'b0, 0, EV_PRESS},
      '{-1, 1'b1, 1'b0, 0, EV_PRESS},
      '{-1, 1'b1, 1'b0, 0, EV_PRESS},
      '{-1, 1'b1, 1'b0, 0, EV_PRESS},
      '{-1, 1'b1, 1'b0, 0, EV_PRESS},
      '{-1, 1'b0, 1'b0, 0, EV_PRESS},
      '{-1, 1'b0, 1'b0, 0, EV_PRESS},
      '{-1, 1'b1, 1'b0, 0, EV_PRESS},
      '{-1, 1'b1, 1'b0, 0, EV_PRESS},
      '{-1, 1'b0, 1'b0, 0, EV_PRESS},
      '{-1, 1'b0, 1'b0, 0, EV_PRESS},
      '{ 1, 1'b0, 1'b1, 0, EV_PRESS},
      '{-1, 1'b0, 1'b1, 1, EV_PRESS},
      '{-1, 1'b1, 1'b1, 0, EV_PRESS},
      '{-1, 1'b1, 1'b1, 1, EV_RELEASE},
      '{-1, 1'b1, 1'b1, 1, EV_CLICK},
      '{ 2, 1'b0, 1'b0, 0, EV_PRESS},
      '{-1, 1'b0, 1'b0, 0, EV_PRESS},
      '{-1, 1'b1, 1'b0, 0, EV_PRESS},
      '{-1, 1'b1, 1'b0, 0, EV_PRESS},
      '{-1, 1'b0, 1'b0, 0, EV_PRESS},
      '{-1, 1'b0, 1'b0, 0, EV_PRESS},
      '{-1, 1'b1, 1'b0, 0, EV_PRESS},
      '{-1, 1'b1, 1'b0, 0, EV_PRESS}
   };

   button_gesture_detector_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_time_stamp   (rsp_time_stamp),
      .rsp_last_of_tick (rsp_last_of_tick),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] sat_inc(input logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   function automatic void note_event(input event_kind_type k);
      gesture_beat_type b;
      b.kind = k;
      b.stamp = tick_cnt;
      b.last = 1'b0;
      tick_events.push_back(b);
   endfunction

   // events of one tick: timer expiries first, then debounce
   function automatic void advance_gesture(input logic pin);
      logic        rep_running;
      logic        level;
      logic [31:0] held;
      rep_running = rep_armed;
      level = pin ^ cfg.pin_invert;
      tick_events.delete();
      if (dc_waiting) begin
         dc_cnt = sat_inc(dc_cnt);
         if (dc_cnt >= cfg.double_click_time) begin
            dc_waiting = 1'b0;
            dc_cnt = '0;
            note_event(EV_CLICK);
         end
      end
      if (lp_armed) begin
         lp_cnt = sat_inc(lp_cnt);
         if (lp_cnt >= cfg.long_press_time) begin
            lp_armed = 1'b0;
            lp_cnt = '0;
            note_event(EV_LONG);
            if (cfg.repeat_enable) begin
               rep_armed = 1'b1;
               rep_cnt = '0;
            end
         end
      end
      if (rep_running && rep_armed) begin
         rep_cnt = sat_inc(rep_cnt);
         if (rep_cnt >= cfg.repeat_period) begin
            rep_cnt = '0;
            note_event(EV_REPEAT);
         end
      end
      if (level != last_sample) begin
         last_sample = level;
         deb_cnt = '0;
         deb_armed = 1'b1;
      end else if (deb_armed) begin
         deb_cnt = sat_inc(deb_cnt);
         if (deb_cnt >= cfg.debounce_time) begin
            deb_armed = 1'b0;
            deb_cnt = '0;
            if (level != stable_pressed) begin
               stable_pressed = level;
               if (level) begin
                  press_tick = tick_cnt;
                  if (cfg.long_press_enable) begin
                     lp_armed = 1'b1;
                     lp_cnt = '0;
                  end
                  note_event(EV_PRESS);
               end else begin
                  held = tick_cnt - press_tick;
                  lp_armed = 1'b0;
                  lp_cnt = '0;
                  rep_armed = 1'b0;
                  rep_cnt = '0;
                  if (held < {16'd0, cfg.long_press_time}) begin
                     if (cfg.double_click_enable) begin
                        if (dc_waiting) begin
                           dc_waiting = 1'b0;
                           dc_cnt = '0;
                           note_event(EV_DOUBLE);
                        end else begin
                           dc_waiting = 1'b1;
                           dc_cnt = '0;
                        end
                     end else begin
                        note_event(EV_CLICK);
                     end
                  end
                  note_event(EV_RELEASE);
               end
            end
         end
      end
      if (tick_events.size() > 0)
         tick_events[tick_events.size()-1].last = 1'b1;
      tick_cnt = tick_cnt + 32'd1;
   endfunction

   // one beat on req; typed rows replace the predicted events
   task automatic send_tick(input logic pin, input logic typed, input int ev_count,
                            input event_kind_type ev_kind);
      logic [31:0] stamp;
      gesture_beat_type b;
      req_valid <= 1'b1;
      req_pin_level <= pin;
      do @(posedge clock); while (req_stall);
      stamp = tick_cnt;
      advance_gesture(pin);
      ticks_sent++;
      if (typed) begin
         if (ev_count != 0) begin
            b.kind = ev_kind;
            b.stamp = stamp;
            b.last = 1'b1;
            events_due.push_back(b);
            predicted_beats++;
         end
      end else begin
         foreach (tick_events[i]) events_due.push_back(tick_events[i]);
         predicted_beats += tick_events.size();
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (events_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         REG_DEBOUNCE_TIME:       cfg.debounce_time = data[15:0];
         REG_LONG_PRESS_TIME:     cfg.long_press_time = data[15:0];
         REG_DOUBLE_CLICK_TIME:   cfg.double_click_time = data[15:0];
         REG_REPEAT_PERIOD:       cfg.repeat_period = data[15:0];
         REG_PIN_INVERT:          cfg.pin_invert = data[0];
         REG_LONG_PRESS_ENABLE:   cfg.long_press_enable = data[0];
         REG_DOUBLE_CLICK_ENABLE: cfg.double_click_enable = data[0];
         REG_REPEAT_ENABLE:       cfg.repeat_enable = data[0];
         default: ;
      endcase
   endtask

   // upper bits carry junk that the block must drop
   task automatic apply_settings(input cfg_type c);
      logic [31:0] junk;
      junk = $urandom;
      write_reg(REG_DEBOUNCE_TIME, {junk[31:16], c.debounce_time});
      write_reg(REG_LONG_PRESS_TIME, {junk[15:0], c.long_press_time});
      write_reg(REG_DOUBLE_CLICK_TIME, {~junk[31:16], c.double_click_time});
      write_reg(REG_REPEAT_PERIOD, {~junk[15:0], c.repeat_period});
      write_reg(REG_PIN_INVERT, {junk[31:1], c.pin_invert});
      write_reg(REG_LONG_PRESS_ENABLE, {~junk[31:1], c.long_press_enable});
      write_reg(REG_DOUBLE_CLICK_ENABLE, {junk[30:0], c.double_click_enable});
      write_reg(REG_REPEAT_ENABLE, {~junk[30:0], c.repeat_enable});
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      settings_count++;
   endtask

   function automatic cfg_type random_settings();
      cfg_type c;
      c.debounce_time = 16'($urandom_range(0, 4));
      c.long_press_time = 16'($urandom_range(0, 12));
      c.double_click_time = 16'($urandom_range(0, 8));
      c.repeat_period = 16'($urandom_range(0, 4));
      c.pin_invert = 1'($urandom_range(0, 1));
      c.long_press_enable = ($urandom_range(0, 3) != 0);
      c.double_click_enable = 1'($urandom_range(0, 1));
      c.repeat_enable = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0: c.long_press_time = 16'hFFFF;
         1: c.double_click_time = 16'hFFFF;
         2: c.repeat_period = 16'hFFFF;
         default: ;
      endcase
      return c;
   endfunction

   always @(posedge clock) begin : rsp_check
      gesture_beat_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (events_due.size() == 0) begin
            $error("unexpected beat: event_kind %0d time_stamp %0d",
                   rsp_event_kind, rsp_time_stamp);
            failures++;
         end else begin
            want = events_due.pop_front();
            beats_checked++;
            if (rsp_event_kind !== want.kind) begin
               $error("event_kind: expected %0d, got %0d", want.kind, rsp_event_kind);
               failures++;
            end
            if (rsp_time_stamp !== want.stamp) begin
               $error("time_stamp: expected %0d, got %0d", want.stamp, rsp_time_stamp);
               failures++;
            end
            if (rsp_last_of_tick !== want.last) begin
               $error("last_of_tick: expected %0d, got %0d", want.last, rsp_last_of_tick);
               failures++;
            end
         end
      end
      rsp_stall <= !steady_flow && ($urandom_range(99) < 14);
   end

   initial begin
      #2_000_000;
      $error("timed out with %0d events outstanding", events_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      cfg_type cfg_now;
      int      phase;
      int      run_left;
      logic    run_pin;
      logic    pin;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NumDirected; r++) begin
         if (directed_rows[r].cfg_sel >= 0) begin
            wait_drained();
            apply_settings(directed_cfgs[directed_rows[r].cfg_sel]);
         end
         send_tick(directed_rows[r].pin, directed_rows[r].typed,
                   directed_rows[r].ev_count, directed_rows[r].ev_kind);
      end

      phase = 0;
      run_left = 0;
      run_pin = 1'b0;
      while (phase < 6) begin
         cfg_now = random_settings();
         if (phase == 1) begin
            cfg_now.debounce_time = 16'hFFFF;
            cfg_now.long_press_time = 16'hFFFF;
            cfg_now.double_click_time = 16'hFFFF;
            cfg_now.repeat_period = 16'hFFFF;
         end else if (phase == 2) begin
            cfg_now.debounce_time = 16'd1;
            cfg_now.long_press_time = 16'hFFFF;
            cfg_now.double_click_time = 16'hFFFF;
            cfg_now.repeat_period = 16'hFFFF;
            cfg_now.double_click_enable = 1'b1;
         end
         wait_drained();
         apply_settings(cfg_now);
         steady_flow = (phase == 0);
         repeat ((phase == 1) ? 12 : 40) begin
            if (!steady_flow) begin
               if ($urandom_range(99) < 14) begin
                  req_valid <= 1'b0;
                  @(posedge clock);
               end else if ($urandom_range(99) < 3) begin
                  wait_drained();
               end
            end
            // level runs of 1 to 10 ticks, with single-tick noise
            if (run_left == 0) begin
               if ($urandom_range(99) < 80)
                  run_pin = ~run_pin;
               run_left = $urandom_range(1, 10);
            end
            pin = ($urandom_range(99) < 8) ? ~run_pin : run_pin;
            run_left--;
            send_tick(pin, 1'b0, 0, EV_PRESS);
         end
         phase++;
      end
      steady_flow = 1'b0;

      req_valid <= 1'b0;
      while (events_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d ticks (%0d from the table) under %0d register settings",
               ticks_sent, NumDirected, settings_count);
      $display("checked %0d of %0d predicted event beats, %0d failures",
               beats_checked, predicted_beats, failures);
      if (failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
